/* design/uhrds_pkg.sv */
// Shared types and constants for the HID report descriptor scanner.
package uhrds_pkg;

  localparam logic [7:0] DESC_TYPE_CONFIG    = 8'h02;
  localparam logic [7:0] DESC_TYPE_INTERFACE = 8'h04;
  localparam logic [7:0] DESC_TYPE_HID       = 8'h21;
  localparam logic [7:0] ENTRY_TYPE_REPORT   = 8'h22;
  localparam logic [7:0] MIN_STD_DESC_LEN    = 8'd9;
  localparam logic [7:0] MIN_DESC_LEN        = 8'd2;
  localparam logic [7:0] HID_COUNT_OFFSET    = 8'd5;
  localparam logic [7:0] HID_ENTRY_OFFSET    = 8'd6;
  localparam logic [7:0] CONFIG_VALUE_OFFSET = 8'd5;
  localparam logic [7:0] IFACE_NUM_OFFSET    = 8'd2;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic {
    RESULT_ENTRY = 1'b0,
    RESULT_END   = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] block_length;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [7:0]   config_value;
    logic [7:0]   interface_number;
    logic [15:0]  report_length;
    logic         stopped_early;
    logic         last;
  } result_t;

  // Results caused by one byte: up to an entry and an end summary
  typedef struct packed {
    logic [1:0] count;
    result_t    slot0;
    result_t    slot1;
  } res_pkt_t;

endpackage

/* design/usb_hid_report_descriptor_scanner.sv */
// Top level of the HID report descriptor scanner: input register and wiring.
// Walks a USB configuration descriptor block fed one byte per transaction and
// reports each HID report descriptor entry with the configuration value and
// interface number in force, plus an end summary on the byte marked tlast.
// A byte is first held in the input register, is processed by the walk
// logic as it moves into the result register, and its results are then
// presented from the result register. Bytes are taken one per cycle while
// out_tready is high and each byte causes at most one result; a byte causing
// two (an entry and the end summary) holds the input while the result
// register drains its second result.
module usb_hid_report_descriptor_scanner
  import uhrds_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte[7:0], block_length[23:8]
  input  logic                   in_tuser,   // first_byte
  input  logic                   in_tlast,   // last_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // config_value[7:0], interface_number[15:8],
                                             // report_length[31:16], stopped_early[32]
  output logic                   out_tuser,  // result_kind
  output logic                   out_tlast   // last
);

  logic     hold_valid_r;
  in_item_t hold_r;
  in_item_t in_item;
  logic     step;
  logic     load_ok;
  res_pkt_t pkt;

  assign in_item.data_byte    = in_tdata[7:0];
  assign in_item.block_length = in_tdata[23:8];
  assign in_item.first_byte   = in_tuser;
  assign in_item.last_byte    = in_tlast;

  // Advance the held byte into the walk when the result register can take it
  assign step      = hold_valid_r && load_ok;
  assign in_tready = !hold_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_tready) begin
      hold_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      hold_r <= in_item;
    end
  end

  uhrds_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .item    (hold_r),
    .pkt     (pkt)
  );

  uhrds_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .pkt        (pkt),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* design/uhrds_walk.sv */
// Descriptor walk state and the per-byte result logic.
module uhrds_walk
  import uhrds_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  in_item_t item,
  output res_pkt_t pkt
);

  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  dlen_r, dlen_nxt;
  logic [7:0]  dtype_r, dtype_nxt;
  logic [7:0]  off_r, off_nxt;
  logic [7:0]  cfg_r, cfg_nxt;
  logic [7:0]  ifc_r, ifc_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  etype_r, etype_nxt;
  logic [7:0]  elow_r, elow_nxt;
  logic        halt_r, halt_nxt;

  logic [15:0] rem_cur;
  logic [7:0]  off_cur;
  logic [7:0]  b;
  logic [7:0]  k;
  logic [15:0] k_prod;
  logic [6:0]  idx;
  logic [7:0]  pos_full;
  logic [1:0]  pos;
  logic [7:0]  off_inc;
  logic        entry_hit;
  logic [15:0] rlen;
  result_t     entry_res;
  result_t     end_res;

  assign b = item.data_byte;

  // Entry index and position within a 3-byte class entry: k/3 by reciprocal
  assign k        = off_cur - HID_ENTRY_OFFSET;
  assign k_prod   = {8'd0, k} * 16'd171;
  assign idx      = k_prod[15:9];
  assign pos_full = k - ({1'b0, idx} * 8'd3);
  assign pos      = pos_full[1:0];

  always_comb begin
    rem_cur   = item.first_byte ? item.block_length : rem_r;
    off_cur   = item.first_byte ? 8'd0 : off_r;
    dlen_nxt  = item.first_byte ? 8'd0 : dlen_r;
    dtype_nxt = item.first_byte ? 8'd0 : dtype_r;
    cfg_nxt   = item.first_byte ? 8'd0 : cfg_r;
    ifc_nxt   = item.first_byte ? 8'd0 : ifc_r;
    cnt_nxt   = item.first_byte ? 8'd0 : cnt_r;
    etype_nxt = item.first_byte ? 8'd0 : etype_r;
    elow_nxt  = item.first_byte ? 8'd0 : elow_r;
    halt_nxt  = item.first_byte ? 1'b0 : halt_r;
    rem_nxt   = rem_cur;
    off_nxt   = off_cur;
    entry_hit = 1'b0;
    rlen      = 16'd0;
    off_inc   = off_cur + 8'd1;

    if (!halt_nxt && rem_cur != 16'd0) begin
      if (off_cur == 8'd0) begin
        if (b < MIN_DESC_LEN || {8'd0, b} > rem_cur) begin
          halt_nxt = 1'b1;
        end else begin
          dlen_nxt  = b;
          dtype_nxt = 8'd0;
          cnt_nxt   = 8'd0;
          etype_nxt = 8'd0;
          elow_nxt  = 8'd0;
        end
      end else if (off_cur == 8'd1) begin
        dtype_nxt = b;
      end else begin
        if (dtype_nxt == DESC_TYPE_CONFIG) begin
          if (off_cur == CONFIG_VALUE_OFFSET && dlen_nxt >= MIN_STD_DESC_LEN) begin
            cfg_nxt = b;
          end
        end else if (dtype_nxt == DESC_TYPE_INTERFACE) begin
          if (off_cur == IFACE_NUM_OFFSET && dlen_nxt >= MIN_STD_DESC_LEN) begin
            ifc_nxt = b;
          end
        end else if (dtype_nxt == DESC_TYPE_HID) begin
          if (off_cur == HID_COUNT_OFFSET) begin
            cnt_nxt = b;
          end else if (off_cur >= HID_ENTRY_OFFSET && {1'b0, idx} < cnt_nxt) begin
            unique case (pos)
              2'd0:    etype_nxt = b;
              2'd1:    elow_nxt  = b;
              default: begin
                if (etype_nxt == ENTRY_TYPE_REPORT) begin
                  entry_hit = 1'b1;
                  rlen      = {b, elow_nxt};
                end
              end
            endcase
          end
        end
      end

      if (!halt_nxt) begin
        rem_nxt = rem_cur - 16'd1;
        off_nxt = (off_inc >= dlen_nxt) ? 8'd0 : off_inc;
      end
    end
  end

  always_comb begin
    entry_res.result_kind      = RESULT_ENTRY;
    entry_res.config_value     = cfg_nxt;
    entry_res.interface_number = ifc_nxt;
    entry_res.report_length    = rlen;
    entry_res.stopped_early    = 1'b0;
    entry_res.last             = ~item.last_byte;

    end_res.result_kind      = RESULT_END;
    end_res.config_value     = cfg_nxt;
    end_res.interface_number = ifc_nxt;
    end_res.report_length    = 16'd0;
    end_res.stopped_early    = halt_nxt;
    end_res.last             = 1'b1;

    pkt.count = {1'b0, entry_hit} + {1'b0, item.last_byte};
    pkt.slot0 = entry_hit ? entry_res : end_res;
    pkt.slot1 = end_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      dlen_r  <= '0;
      dtype_r <= '0;
      off_r   <= '0;
      cfg_r   <= '0;
      ifc_r   <= '0;
      cnt_r   <= '0;
      etype_r <= '0;
      elow_r  <= '0;
      halt_r  <= 1'b0;
    end else if (step_en) begin
      rem_r   <= rem_nxt;
      dlen_r  <= dlen_nxt;
      dtype_r <= dtype_nxt;
      off_r   <= off_nxt;
      cfg_r   <= cfg_nxt;
      ifc_r   <= ifc_nxt;
      cnt_r   <= cnt_nxt;
      etype_r <= etype_nxt;
      elow_r  <= elow_nxt;
      halt_r  <= halt_nxt;
    end
  end

endmodule

/* design/uhrds_outbuf.sv */
// Result register holding the up to two results of one byte.
module uhrds_outbuf
  import uhrds_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  res_pkt_t               pkt,
  output logic                   load_ok,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  logic [1:0] cnt_r, cnt_nxt;
  result_t    slot0_r, slot0_nxt;
  result_t    slot1_r, slot1_nxt;
  logic       pop;

  assign pop     = out_tvalid && out_tready;
  // Take a new packet when empty or when the only result leaves now
  assign load_ok = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (load) begin
      cnt_nxt   = pkt.count;
      slot0_nxt = pkt.slot0;
      slot1_nxt = pkt.slot1;
    end else if (pop) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tuser  = slot0_r.result_kind;
  assign out_tlast  = slot0_r.last;
  assign out_tdata  = {7'd0, slot0_r.stopped_early, slot0_r.report_length,
                       slot0_r.interface_number, slot0_r.config_value};

endmodule
